// ===== sv/bz2_block_marker_finder_macros.svh =====
// Assertion macros used by the marker finder match stage
`ifndef BZ2_BLOCK_MARKER_FINDER_MACROS_SVH
`define BZ2_BLOCK_MARKER_FINDER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst_n is low
`define BBMF_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);
// next-cycle implication
`define BBMF_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);
`else
`define BBMF_ASSERT_IMP(lbl, ant, con, msg)
`define BBMF_ASSERT_NXT(lbl, ant, con, msg)
`endif

`endif

// ===== sv/bbmf_pkg.sv =====
package bbmf_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int MAGIC_BITS  = 48;
    localparam int WINDOW_BITS = 55;
    localparam int POS_BITS    = 35;
    localparam int POS_CALC_W  = (COUNT_BITS + 3 > POS_BITS) ? COUNT_BITS + 3 : POS_BITS;
    localparam int MIN_BYTES   = MAGIC_BITS / 8;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [WINDOW_BITS-1:0] window_t;
    typedef logic [MAGIC_BITS-1:0]  magic_t;
    typedef logic [POS_BITS-1:0]    pos_t;
    typedef logic [2:0]             shift_t;

    typedef enum logic [0:0] {
        REG_BLOCK_MAGIC = 1'b0,
        REG_END_MAGIC   = 1'b1
    } reg_index_t;

    localparam magic_t BLOCK_MAGIC_RST = 48'h3141_5926_5359;
    localparam magic_t END_MAGIC_RST   = 48'h1772_4538_5090;

    // window and count after the newest word, handed from window stage to match stage
    typedef struct packed {
        logic    valid;
        window_t window;
        count_t  count;
    } snap_t;

    typedef struct packed {
        logic   found;
        shift_t shift;
        pos_t   pos;
    } hit_t;

    // Test all eight alignments ending in the newest byte; smallest shift wins.
    function automatic hit_t search(window_t window, count_t count, magic_t magic);
        hit_t                  hit;
        shift_t                tail;
        window_t               shifted;
        logic                  enough;
        logic [POS_CALC_W-1:0] bits;
        hit  = '0;
        bits = POS_CALC_W'({count, 3'b000});
        for (int s = 7; s >= 0; s--)
        begin
            tail    = 3'(~3'(s) + 3'd1);
            shifted = window >> tail;
            if (tail == 3'd0)
                enough = (count >= count_t'(MIN_BYTES));
            else
                enough = (count >= count_t'(MIN_BYTES + 1));
            if (enough && (shifted[MAGIC_BITS-1:0] == magic))
            begin
                hit.found = 1'b1;
                hit.shift = 3'(s);
                hit.pos   = POS_BITS'(bits - POS_CALC_W'(tail) - POS_CALC_W'(MAGIC_BITS));
            end
        end
        return hit;
    endfunction

endpackage

// ===== sv/bbmf_if.sv =====
interface bbmf_in_if;
    import bbmf_pkg::*;

    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface bbmf_out_if;
    import bbmf_pkg::*;

    logic   valid;
    logic   ready;
    logic   block_found;
    logic   end_found;
    shift_t bit_shift;
    pos_t   bit_position;

    modport source (output valid, output block_found, output end_found, output bit_shift,
                    output bit_position, input ready);
    modport sink   (input valid, input block_found, input end_found, input bit_shift,
                    input bit_position, output ready);
endinterface

// ===== sv/bbmf_window.sv =====
module bbmf_window
(
    input  logic            clk,
    input  logic            rst_n,
    bbmf_in_if.sink         in_ch,
    input  logic            take,
    output bbmf_pkg::snap_t snap
);
    import bbmf_pkg::*;

    logic    valid_reg, valid_next;
    window_t window_reg, window_next;
    count_t  count_reg, count_next;
    window_t window_base;
    count_t  count_base;
    logic    accept;

    assign in_ch.ready = !valid_reg || take;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        window_base = in_ch.stream_start ? '0 : window_reg;
        count_base  = in_ch.stream_start ? '0 : count_reg;
        window_next = window_reg;
        count_next  = count_reg;
        valid_next  = valid_reg && !take;
        if (accept)
        begin
            window_next = WINDOW_BITS'({window_base, in_ch.data_byte});
            // saturate at all ones
            count_next  = (&count_base) ? count_base : count_base + count_t'(1);
            valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            window_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    assign snap.valid  = valid_reg;
    assign snap.window = window_reg;
    assign snap.count  = count_reg;

endmodule

// ===== sv/bbmf_match.sv =====
`include "bz2_block_marker_finder_macros.svh"

module bbmf_match
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  bbmf_pkg::reg_index_t cfg_index,
    input  bbmf_pkg::magic_t     cfg_data,
    input  bbmf_pkg::snap_t      snap,
    output logic                 take,
    bbmf_out_if.source           out_ch
);
    import bbmf_pkg::*;

    magic_t block_magic_reg;
    magic_t end_magic_reg;
    logic   out_valid_reg, out_valid_next;
    logic   block_found_reg;
    logic   end_found_reg;
    shift_t bit_shift_reg;
    pos_t   bit_position_reg;
    hit_t   hit_block;
    hit_t   hit_end;
    hit_t   hit_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_magic_reg <= BLOCK_MAGIC_RST;
            end_magic_reg   <= END_MAGIC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_MAGIC: block_magic_reg <= cfg_data;
                REG_END_MAGIC:   end_magic_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        hit_block = search(snap.window, snap.count, block_magic_reg);
        hit_end   = search(snap.window, snap.count, end_magic_reg);
        // block match describes the result when both hit
        if (hit_block.found)
            hit_sel = hit_block;
        else
            hit_sel = hit_end;
    end

    assign take           = !out_valid_reg || out_ch.ready;
    assign out_valid_next = take ? snap.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && snap.valid)
        begin
            block_found_reg  <= hit_block.found;
            end_found_reg    <= hit_end.found;
            bit_shift_reg    <= hit_sel.shift;
            bit_position_reg <= hit_sel.pos;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.block_found  = block_found_reg;
    assign out_ch.end_found    = end_found_reg;
    assign out_ch.bit_shift    = bit_shift_reg;
    assign out_ch.bit_position = bit_position_reg;

    `BBMF_ASSERT_IMP(a_no_hit_zero, out_valid_reg && !block_found_reg && !end_found_reg, bit_shift_reg == 3'd0 && bit_position_reg == '0, "fields not zero without a match")
    `BBMF_ASSERT_IMP(a_pos_aligns_shift, out_valid_reg && (block_found_reg || end_found_reg), bit_position_reg[2:0] == bit_shift_reg, "position disagrees with shift")
    `BBMF_ASSERT_IMP(a_short_stream, snap.valid && snap.count < count_t'(MIN_BYTES), !hit_block.found && !hit_end.found, "match before six bytes seen")
    `BBMF_ASSERT_NXT(a_stage_held, snap.valid && !take, snap.valid, "window stage dropped a word")

endmodule

// ===== sv/bz2_block_marker_finder.sv =====
// Bit-aligned search for the two 48-bit bzip2 markers in a byte stream. Each
// accepted word shifts one byte (MSB first) into a 55-bit window and bumps a
// saturating byte count; stream_start clears both first. One result word
// follows every input word, via the window and result registers: block_found
// and end_found flag a marker ending inside that byte, bit_shift gives its
// start offset in its first byte (smallest offset when several align) and
// bit_position its absolute bit index, both for the block marker when both
// match. The block takes one byte per cycle while not stalled, set by the
// single window shift register feeding sixteen parallel 48-bit compares;
// while a result waits it takes one more word into the window stage and then
// holds. Write the magic registers only while no word is in flight.
module bz2_block_marker_finder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  bbmf_pkg::reg_index_t cfg_index,
    input  bbmf_pkg::magic_t     cfg_data,
    bbmf_in_if.sink              in_ch,
    bbmf_out_if.source           out_ch
);
    import bbmf_pkg::*;

    snap_t snap;
    logic  take;

    bbmf_window u_window
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .take  (take),
        .snap  (snap)
    );

    bbmf_match u_match
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .snap      (snap),
        .take      (take),
        .out_ch    (out_ch)
    );

endmodule

// ===== tb/bz2_block_marker_finder_test.sv =====
`timescale 1ns / 100ps

module bz2_block_marker_finder_test;
    import bbmf_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASE_ITEMS  = 60;

    typedef struct packed {
        bit        block_found;
        bit        end_found;
        bit [2:0]  bit_shift;
        bit [34:0] bit_position;
    } marker_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    reg_index_t cfg_index;
    magic_t     cfg_data;

    bbmf_in_if  in_ch ();
    bbmf_out_if out_ch ();

    bz2_block_marker_finder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor copy of the window, byte count and patterns
    bit [54:0] scan_window;
    bit [31:0] scan_bytes;
    bit [47:0] block_pattern;
    bit [47:0] end_pattern;

    marker_t     pending_markers[$];
    int unsigned cycle_count   = 0;
    int unsigned bytes_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned hits_seen     = 0;
    int unsigned settings_used = 0;
    int unsigned error_count   = 0;
    bit          no_idle       = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[bz2_block_marker_finder] ERROR");
            $finish;
        end
    end

    // try every alignment ending in the newest byte, smallest offset first
    function automatic bit align_match(input bit [47:0] pattern, output bit [2:0] shift,
                                       output bit [34:0] position);
        bit [63:0] total_bits;
        bit [2:0]  tail;
        total_bits = {29'b0, scan_bytes, 3'b000};
        shift      = '0;
        position   = '0;
        for (int s = 0; s < 8; s++)
        begin
            tail = 3'(8 - s);
            if (total_bits >= 64'(48 + tail) && scan_window[tail +: 48] == pattern)
            begin
                shift    = 3'(s);
                position = 35'(total_bits - 64'(tail) - 64'd48);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic marker_t predict_marker(input bit [7:0] data, input bit start);
        marker_t   r;
        bit [2:0]  bs, es;
        bit [34:0] bp, ep;
        bit        bf, ef;
        if (start)
        begin
            scan_window = '0;
            scan_bytes  = '0;
        end
        scan_window = {scan_window[46:0], data};
        if (scan_bytes != '1)
            scan_bytes++;
        bf = align_match(block_pattern, bs, bp);
        ef = align_match(end_pattern, es, ep);
        r.block_found  = bf;
        r.end_found    = ef;
        r.bit_shift    = bf ? bs : (ef ? es : 3'd0);
        r.bit_position = bf ? bp : (ef ? ep : 35'd0);
        return r;
    endfunction

    task automatic send_byte(input bit [7:0] data, input bit start);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= data;
        in_ch.stream_start <= start;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pending_markers.push_back(predict_marker(data, start));
        bytes_sent++;
    endtask

    // place the pattern at the given bit offset inside random bits, MSB first
    task automatic send_marker(input bit [47:0] pattern, input int shift, input bit start);
        bit [63:0] bits;
        int        n;
        bits = {$urandom(), $urandom()};
        bits[63 - shift -: 48] = pattern;
        n = (shift == 0) ? 6 : 7;
        for (int i = 0; i < n; i++)
            send_byte(bits[63 - 8*i -: 8], start && i == 0);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_markers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_patterns(input bit [47:0] blk, input bit [47:0] fin);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_BLOCK_MAGIC;
        cfg_data  <= blk;
        @(posedge clk);
        block_pattern = blk;
        cfg_index <= REG_END_MAGIC;
        cfg_data  <= fin;
        @(posedge clk);
        end_pattern = fin;
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic test_aligned_block();
        bit [7:0] seq[6];
        seq = '{8'h31, 8'h41, 8'h59, 8'h26, 8'h53, 8'h59};
        for (int i = 0; i < 6; i++)
            send_byte(seq[i], i == 0);
    endtask

    // cleared window equals the pattern, yet nothing may match before 48 bits
    task automatic test_short_stream();
        load_patterns(48'h0, '1);
        for (int i = 0; i < 7; i++)
            send_byte(8'h00, i == 0);
        for (int i = 0; i < 6; i++)
            send_byte(8'hFF, i == 0);
    endtask

    task automatic test_dual_match();
        bit [47:0] pat;
        pat = 48'({$urandom(), $urandom()});
        load_patterns(pat, pat);
        send_marker(pat, 5, 1'b1);
    endtask

    task automatic test_random_streams();
        bit [47:0]   blk, fin, pat;
        int          pick, n;
        bit          st;
        int unsigned base, phase_end;
        base = bytes_sent;
        while (bytes_sent - base < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 5);
            case (pick)
                0: begin blk = BLOCK_MAGIC_RST; fin = END_MAGIC_RST; end
                1: begin blk = '0; fin = '1; end
                2: begin blk = '1; fin = '0; end
                3: begin blk = 48'({$urandom(), $urandom()}); fin = blk; end
                default:
                begin
                    blk = 48'({$urandom(), $urandom()});
                    fin = 48'({$urandom(), $urandom()});
                end
            endcase
            load_patterns(blk, fin);
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 7);
                if (pick < 5)
                begin
                    st = 1'($urandom_range(0, 1));
                    n  = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom()), st && i == 0);
                    pat = $urandom_range(0, 1) ? blk : fin;
                    send_marker(pat, $urandom_range(0, 7), st && n == 0);
                end
                else if (pick == 5)
                begin
                    // near miss: one bit of the pattern flipped
                    pat = ($urandom_range(0, 1) ? blk : fin) ^ (48'd1 << $urandom_range(0, 47));
                    send_marker(pat, $urandom_range(0, 7), 1'b0);
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        send_byte(8'($urandom()), $urandom_range(0, 15) == 0);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_checker
        int      stall;
        marker_t want;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            if (pending_markers.size() == 0)
            begin
                $error("result word with no prediction waiting");
                error_count++;
            end
            else
            begin
                want = pending_markers.pop_front();
                if (out_ch.block_found !== want.block_found)
                begin
                    $error("block_found: expected %0d, got %0d",
                           want.block_found, out_ch.block_found);
                    error_count++;
                end
                if (out_ch.end_found !== want.end_found)
                begin
                    $error("end_found: expected %0d, got %0d", want.end_found, out_ch.end_found);
                    error_count++;
                end
                if (out_ch.bit_shift !== want.bit_shift)
                begin
                    $error("bit_shift: expected %0d, got %0d", want.bit_shift, out_ch.bit_shift);
                    error_count++;
                end
                if (out_ch.bit_position !== want.bit_position)
                begin
                    $error("bit_position: expected %0d, got %0d",
                           want.bit_position, out_ch.bit_position);
                    error_count++;
                end
                words_checked++;
                if (want.block_found || want.end_found)
                    hits_seen++;
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_BLOCK_MAGIC;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.stream_start <= 1'b0;
        scan_window   = '0;
        scan_bytes    = '0;
        block_pattern = BLOCK_MAGIC_RST;
        end_pattern   = END_MAGIC_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_aligned_block();
        test_short_stream();
        test_dual_match();
        test_random_streams();
        wait_idle();

        $display("Checked %0d result words from %0d stream bytes, %0d with a marker hit,",
                 words_checked, bytes_sent, hits_seen);
        $display("across %0d pattern settings incl. reset, all-zero, all-ones and equal pairs.",
                 settings_used);
        if (error_count == 0)
            $display("[bz2_block_marker_finder] OK");
        else
            $display("[bz2_block_marker_finder] ERROR");
        $finish;
    end

endmodule
